@@ sv/bsp_pkg.sv @@
package bsp_pkg;

   localparam int FRACTION_BITS = 8;
   localparam int PIX_W = 8;
   localparam int BGQ_W = 16;
   localparam int CNT_W = 21;
   localparam int SUM_W = 28;
   localparam int TOT_W = 36;
   localparam int NUM_COUNTERS = 15;
   localparam int CIDX_W = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
   localparam logic [BGQ_W-1:0] BGQ_MAX = 16'd65280;

   localparam logic [CSR_IDX_W-1:0] REG_BACKGROUND_SHIFT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_SHIFT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOW_LEARNING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BACKGROUND_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEARN_THRESHOLD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STABLE_THRESHOLD = 3'd6;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_COUNTER = 1'b1;

   localparam logic [CIDX_W-1:0] CNT_GLOBAL_BG = 4'd0;
   localparam logic [CIDX_W-1:0] CNT_GULLY_BG = 4'd1;
   localparam logic [CIDX_W-1:0] CNT_STATIC_BG = 4'd2;
   localparam logic [CIDX_W-1:0] CNT_GLOBAL_FRAME = 4'd3;
   localparam logic [CIDX_W-1:0] CNT_GULLY_FRAME = 4'd4;
   localparam logic [CIDX_W-1:0] CNT_STATIC_FRAME = 4'd5;
   localparam logic [CIDX_W-1:0] CNT_ZONE0 = 4'd6;
   localparam logic [CIDX_W-1:0] CNT_BG_DIFF_SUM = 4'd10;
   localparam logic [CIDX_W-1:0] CNT_FRAME_DIFF_SUM = 4'd11;
   localparam logic [CIDX_W-1:0] CNT_OVERLAP = 4'd12;
   localparam logic [CIDX_W-1:0] CNT_LEARNED = 4'd13;
   localparam logic [CIDX_W-1:0] CNT_BG_TOTAL = 4'd14;

   typedef struct packed {
      logic [PIX_W-1:0] current_pixel;
      logic [PIX_W-1:0] previous_pixel;
      logic [BGQ_W-1:0] bkg_q8;
      logic             in_gully;
      logic             in_static;
      logic [1:0]       quadrant;
      logic             last_pixel;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [BGQ_W-1:0]  new_bkg_q8;
      logic              background_changed;
      logic              frame_changed;
      logic              foreground_mark;
      logic              moving_overlap;
      logic              learned;
      logic [CIDX_W-1:0] counter_index;
      logic [TOT_W-1:0]  counter_value;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic signed [8:0] background_shift;
      logic signed [8:0] frm_shift;
      logic              allow_learning;
      logic [7:0]        background_threshold;
      logic [7:0]        frame_threshold;
      logic [7:0]        learn_threshold;
      logic [7:0]        stable_threshold;
   } cfg_type;

   typedef struct packed {
      logic [8:0]       bg_diff;
      logic [7:0]       frm_diff;
      logic             bg_changed;
      logic             frame_changed;
      logic             learned;
      logic             in_gully;
      logic             in_static;
      logic [1:0]       quadrant;
      logic [BGQ_W-1:0] new_bgq;
   } pix_stat_type;

endpackage

@@ sv/bsp_pixel_calc.sv @@
module bsp_pixel_calc #(
   parameter int UPDATE_DIVISOR = 16
) (
   input  bsp_pkg::req_type      pix,
   input  bsp_pkg::cfg_type      cfg,
   output bsp_pkg::pix_stat_type stat
);
   import bsp_pkg::*;

   localparam int MAG_W = 17;
   localparam int DIV_LOG = $clog2(UPDATE_DIVISOR);
   localparam int RECIP_SHIFT = MAG_W + DIV_LOG;
   localparam int RECIP_W = MAG_W + 1;
   localparam int RECIP_INT = ((2 ** RECIP_SHIFT) + UPDATE_DIVISOR - 1) / UPDATE_DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);
   localparam int PROD_W = MAG_W + RECIP_W;

   logic signed [10:0] cur_ext;
   logic signed [10:0] cb_raw;
   logic signed [10:0] cf_raw;
   logic [PIX_W-1:0]   cb;
   logic [PIX_W-1:0]   cf;
   logic [16:0]        bg_round_sum;
   logic [8:0]         bg_round;
   logic signed [9:0]  bd_raw;
   logic signed [9:0]  bd_abs;
   logic signed [8:0]  fd_raw;
   logic signed [8:0]  fd_abs;
   logic               bg_chg;
   logic               fr_chg;
   logic               learn;
   logic signed [17:0] delta;
   logic signed [17:0] delta_neg;
   logic [MAG_W-1:0]   mag;
   logic [PROD_W-1:0]  prod;
   logic [MAG_W-1:0]   quot;
   logic signed [18:0] quot_s;
   logic signed [18:0] upd;
   logic [BGQ_W-1:0]   upd_clamped;

   always_comb begin
      cur_ext = {3'b000, pix.current_pixel};
      cb_raw = cur_ext - {{2{cfg.background_shift[8]}}, cfg.background_shift};
      cf_raw = cur_ext - {{2{cfg.frm_shift[8]}}, cfg.frm_shift};
      if (cb_raw < 0) begin
         cb = '0;
      end else if (cb_raw > $signed({3'b000, PIX_MAX})) begin
         cb = PIX_MAX;
      end else begin
         cb = cb_raw[7:0];
      end
      if (cf_raw < 0) begin
         cf = '0;
      end else if (cf_raw > $signed({3'b000, PIX_MAX})) begin
         cf = PIX_MAX;
      end else begin
         cf = cf_raw[7:0];
      end

      bg_round_sum = {1'b0, pix.bkg_q8} + 17'(1 << (FRACTION_BITS - 1));
      bg_round = bg_round_sum[16:FRACTION_BITS];

      bd_raw = $signed({2'b00, cb}) - $signed({1'b0, bg_round});
      bd_abs = (bd_raw < 0) ? -bd_raw : bd_raw;
      fd_raw = $signed({1'b0, cf}) - $signed({1'b0, pix.previous_pixel});
      fd_abs = (fd_raw < 0) ? -fd_raw : fd_raw;

      bg_chg = bd_abs[8:0] > {1'b0, cfg.background_threshold};
      fr_chg = fd_abs[7:0] > cfg.frame_threshold;
      learn = cfg.allow_learning && (bd_abs[8:0] <= {1'b0, cfg.learn_threshold}) &&
              (fd_abs[7:0] <= cfg.stable_threshold);

      delta = $signed({2'b00, pix.current_pixel, 8'h00}) - $signed({2'b00, pix.bkg_q8});
      delta_neg = -delta;
      mag = delta[17] ? delta_neg[MAG_W-1:0] : delta[MAG_W-1:0];
      prod = PROD_W'(mag) * PROD_W'(RECIP);
      quot = MAG_W'(prod >> RECIP_SHIFT);
      quot_s = delta[17] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
      upd = $signed({3'b000, pix.bkg_q8}) + quot_s;
      if (upd < 0) begin
         upd_clamped = '0;
      end else if (upd > $signed({3'b000, BGQ_MAX})) begin
         upd_clamped = BGQ_MAX;
      end else begin
         upd_clamped = upd[15:0];
      end

      stat.bg_diff = bd_abs[8:0];
      stat.frm_diff = fd_abs[7:0];
      stat.bg_changed = bg_chg;
      stat.frame_changed = fr_chg;
      stat.learned = learn;
      stat.in_gully = pix.in_gully;
      stat.in_static = pix.in_static;
      stat.quadrant = pix.quadrant;
      stat.new_bgq = learn ? upd_clamped : pix.bkg_q8;
   end

endmodule

@@ sv/bsp_frame_stats.sv @@
module bsp_frame_stats (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update,
   input  logic                         close_frame,
   input  bsp_pkg::pix_stat_type        stat,
   input  logic [bsp_pkg::CIDX_W-1:0]   rd_index,
   output logic [bsp_pkg::TOT_W-1:0]    rd_value
);
   import bsp_pkg::*;

   logic [CNT_W-1:0] bg_cnt_ff [3];
   logic [CNT_W-1:0] bg_cnt_in [3];
   logic [CNT_W-1:0] fr_cnt_ff [3];
   logic [CNT_W-1:0] fr_cnt_in [3];
   logic [CNT_W-1:0] quad_cnt_ff [4];
   logic [CNT_W-1:0] quad_cnt_in [4];
   logic [SUM_W-1:0] bd_sum_ff;
   logic [SUM_W-1:0] bd_sum_in;
   logic [SUM_W-1:0] fd_sum_ff;
   logic [SUM_W-1:0] fd_sum_in;
   logic [CNT_W-1:0] ovl_cnt_ff;
   logic [CNT_W-1:0] ovl_cnt_in;
   logic [CNT_W-1:0] lrn_cnt_ff;
   logic [CNT_W-1:0] lrn_cnt_in;
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] total_in;
   logic [TOT_W-1:0] snap_ff [NUM_COUNTERS];
   logic [TOT_W-1:0] snap_in [NUM_COUNTERS];
   logic [SUM_W:0]   bd_sum_wide;
   logic [SUM_W:0]   fd_sum_wide;
   logic [TOT_W:0]   total_wide;
   logic             bg_hit [3];
   logic             fr_hit [3];

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] cnt, logic hit);
      logic [CNT_W-1:0] res;
      res = cnt;
      if (hit && (cnt != '1)) begin
         res = cnt + 1'b1;
      end
      return res;
   endfunction

   always_comb begin
      bg_hit[0] = stat.bg_changed;
      bg_hit[1] = stat.bg_changed && stat.in_gully;
      bg_hit[2] = stat.bg_changed && stat.in_static;
      fr_hit[0] = stat.frame_changed;
      fr_hit[1] = stat.frame_changed && stat.in_gully;
      fr_hit[2] = stat.frame_changed && stat.in_static;
      for (int i = 0; i < 3; i++) begin
         bg_cnt_in[i] = sat_inc(bg_cnt_ff[i], bg_hit[i]);
         fr_cnt_in[i] = sat_inc(fr_cnt_ff[i], fr_hit[i]);
      end
      for (int i = 0; i < 4; i++) begin
         quad_cnt_in[i] = sat_inc(quad_cnt_ff[i], stat.frame_changed && !stat.in_gully &&
                                  (stat.quadrant == 2'(i)));
      end
      bd_sum_wide = {1'b0, bd_sum_ff} + (SUM_W + 1)'(stat.bg_diff);
      bd_sum_in = bd_sum_wide[SUM_W] ? '1 : bd_sum_wide[SUM_W-1:0];
      fd_sum_wide = {1'b0, fd_sum_ff} + (SUM_W + 1)'(stat.frm_diff);
      fd_sum_in = fd_sum_wide[SUM_W] ? '1 : fd_sum_wide[SUM_W-1:0];
      ovl_cnt_in = sat_inc(ovl_cnt_ff, stat.in_gully && stat.bg_changed && stat.frame_changed);
      lrn_cnt_in = sat_inc(lrn_cnt_ff, stat.learned);
      total_wide = {1'b0, total_ff} + (TOT_W + 1)'(stat.new_bgq);
      total_in = total_wide[TOT_W] ? '1 : total_wide[TOT_W-1:0];

      for (int i = 0; i < 3; i++) begin
         snap_in[int'(CNT_GLOBAL_BG) + i] = TOT_W'(bg_cnt_in[i]);
         snap_in[int'(CNT_GLOBAL_FRAME) + i] = TOT_W'(fr_cnt_in[i]);
      end
      for (int i = 0; i < 4; i++) begin
         snap_in[int'(CNT_ZONE0) + i] = TOT_W'(quad_cnt_in[i]);
      end
      snap_in[CNT_BG_DIFF_SUM] = TOT_W'(bd_sum_in);
      snap_in[CNT_FRAME_DIFF_SUM] = TOT_W'(fd_sum_in);
      snap_in[CNT_OVERLAP] = TOT_W'(ovl_cnt_in);
      snap_in[CNT_LEARNED] = TOT_W'(lrn_cnt_in);
      snap_in[CNT_BG_TOTAL] = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            bg_cnt_ff[i] <= '0;
            fr_cnt_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            quad_cnt_ff[i] <= '0;
         end
         bd_sum_ff <= '0;
         fd_sum_ff <= '0;
         ovl_cnt_ff <= '0;
         lrn_cnt_ff <= '0;
         total_ff <= '0;
      end else if (update) begin
         for (int i = 0; i < 3; i++) begin
            bg_cnt_ff[i] <= close_frame ? '0 : bg_cnt_in[i];
            fr_cnt_ff[i] <= close_frame ? '0 : fr_cnt_in[i];
         end
         for (int i = 0; i < 4; i++) begin
            quad_cnt_ff[i] <= close_frame ? '0 : quad_cnt_in[i];
         end
         bd_sum_ff <= close_frame ? '0 : bd_sum_in;
         fd_sum_ff <= close_frame ? '0 : fd_sum_in;
         ovl_cnt_ff <= close_frame ? '0 : ovl_cnt_in;
         lrn_cnt_ff <= close_frame ? '0 : lrn_cnt_in;
         total_ff <= close_frame ? '0 : total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update && close_frame) begin
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            snap_ff[i] <= snap_in[i];
         end
      end
   end

   assign rd_value = (rd_index <= CNT_BG_TOTAL) ? snap_ff[rd_index] : '0;

endmodule

@@ sv/background_subtract_pixel_engine_unit.sv @@
// Background subtraction pixel engine.
// The request channel (req_valid, req_stall, req_data) carries one pixel per beat:
// current and previous gray value, stored Q8 background, region bits, quadrant and
// an end-of-frame flag. The response channel (rsp_valid, rsp_stall, rsp_data) gives
// one pixel result per pixel, and after the pixel flagged last, fifteen frame
// counter beats in fixed order; last_result marks the final beat of each pixel.
// Thresholds and brightness shifts are set through the csr_ write port; the user
// must write them between frames, as the block itself does not enforce it.
// A pixel beat is registered at the input and its result, computed combinationally,
// is registered in the output register when that register is free. One pixel is
// accepted per cycle while the output is not stalled and no counter beats are
// pending; after the last pixel of a frame, the fifteen counter beats drain first.
// When rsp_stall is high on a valid beat, the output register holds it and the
// input register fills, after which req_stall is raised.
// Reset clears both valid flags, the frame counters and the registers to their
// defaults; the block can take a beat as soon as reset is released.
module background_subtract_pixel_engine_unit #(
   parameter int UPDATE_DIVISOR = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bsp_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bsp_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [bsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bsp_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   req_type          pix_ff;
   logic             pix_valid_ff;
   logic             pix_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             emit_ff;
   logic             emit_in;
   logic [CIDX_W-1:0] emit_idx_ff;
   logic [CIDX_W-1:0] emit_idx_in;
   logic             req_take;
   logic             out_free;
   logic             pix_adv;
   logic             pix_load;
   pix_stat_type     stat;
   logic [TOT_W-1:0] cnt_value;

   bsp_pixel_calc #(
      .UPDATE_DIVISOR(UPDATE_DIVISOR)
   ) u_calc (
      .pix  (pix_ff),
      .cfg  (cfg_ff),
      .stat (stat)
   );

   bsp_frame_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .update      (pix_load),
      .close_frame (pix_ff.last_pixel),
      .stat        (stat),
      .rd_index    (emit_idx_ff),
      .rd_value    (cnt_value)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_BACKGROUND_SHIFT: cfg_in.background_shift = $signed(csr_wdata);
            REG_FRAME_SHIFT: cfg_in.frm_shift = $signed(csr_wdata);
            REG_ALLOW_LEARNING: cfg_in.allow_learning = csr_wdata[0];
            REG_BACKGROUND_THRESHOLD: cfg_in.background_threshold = csr_wdata[7:0];
            REG_FRAME_THRESHOLD: cfg_in.frame_threshold = csr_wdata[7:0];
            REG_LEARN_THRESHOLD: cfg_in.learn_threshold = csr_wdata[7:0];
            REG_STABLE_THRESHOLD: cfg_in.stable_threshold = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      pix_adv = out_free && !emit_ff;
      pix_load = pix_adv && pix_valid_ff;
      req_stall = pix_valid_ff && !pix_adv;
      req_take = req_valid && !req_stall;
      if (req_take) begin
         pix_valid_in = 1'b1;
      end else if (pix_adv) begin
         pix_valid_in = 1'b0;
      end else begin
         pix_valid_in = pix_valid_ff;
      end

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      emit_in = emit_ff;
      emit_idx_in = emit_idx_ff;
      if (out_free) begin
         if (emit_ff) begin
            rsp_in = '0;
            rsp_in.kind = KIND_COUNTER;
            rsp_in.counter_index = emit_idx_ff;
            rsp_in.counter_value = cnt_value;
            rsp_in.last_result = (emit_idx_ff == CNT_BG_TOTAL);
            rsp_valid_in = 1'b1;
            if (emit_idx_ff == CNT_BG_TOTAL) begin
               emit_in = 1'b0;
            end else begin
               emit_idx_in = emit_idx_ff + 1'b1;
            end
         end else if (pix_valid_ff) begin
            rsp_in = '0;
            rsp_in.kind = KIND_PIXEL;
            rsp_in.new_bkg_q8 = stat.new_bgq;
            rsp_in.background_changed = stat.bg_changed;
            rsp_in.frame_changed = stat.frame_changed;
            rsp_in.foreground_mark = stat.in_gully && stat.bg_changed;
            rsp_in.moving_overlap = stat.in_gully && stat.bg_changed && stat.frame_changed;
            rsp_in.learned = stat.learned;
            rsp_in.last_result = !pix_ff.last_pixel;
            rsp_valid_in = 1'b1;
            if (pix_ff.last_pixel) begin
               emit_in = 1'b1;
               emit_idx_in = CNT_GLOBAL_BG;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.background_shift <= '0;
         cfg_ff.frm_shift <= '0;
         cfg_ff.allow_learning <= 1'b0;
         cfg_ff.background_threshold <= 8'd25;
         cfg_ff.frame_threshold <= 8'd15;
         cfg_ff.learn_threshold <= 8'd10;
         cfg_ff.stable_threshold <= 8'd5;
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         emit_ff <= 1'b0;
         emit_idx_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_ff <= emit_in;
         emit_idx_ff <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pix_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import bsp_pkg::*;

   localparam int UPDATE_DIVISOR = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_type pixel_queue[$];
   rsp_type expected_beats[$];
   longint frame_tally[NUM_COUNTERS];
   bit req_accepted = 1'b0;
   int error_count = 0;
   int send_idle_pct = 11;
   int recv_stall_pct = 49;

   int bkg_offset = 0;
   int fr_shift = 0;
   bit learn_en = 1'b0;
   int bg_thr = 25;
   int fr_thr = 15;
   int learn_thr = 10;
   int stable_thr = 5;

   background_subtract_pixel_engine_unit #(
      .UPDATE_DIVISOR(UPDATE_DIVISOR)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint sat_add(longint acc, int add, int width);
      longint top;
      top = (longint'(1) << width) - 1;
      return (acc + add > top) ? top : acc + add;
   endfunction

   function automatic void clear_tally();
      foreach (frame_tally[k]) frame_tally[k] = 0;
   endfunction

   function automatic void predict_pixel(req_type px);
      int cur, prev, bgq, bg_round, cb, cf, bd, fd, newbg, k;
      bit bchg, fchg, learn;
      rsp_type r;
      cur = int'(px.current_pixel);
      prev = int'(px.previous_pixel);
      bgq = int'(px.bkg_q8);
      bg_round = (bgq + (1 << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      cb = clamp_int(cur - bkg_offset, 0, int'(PIX_MAX));
      cf = clamp_int(cur - fr_shift, 0, int'(PIX_MAX));
      bd = cb - bg_round;
      fd = cf - prev;
      if (bd < 0) bd = -bd;
      if (fd < 0) fd = -fd;
      bchg = bd > bg_thr;
      fchg = fd > fr_thr;
      learn = learn_en && bd <= learn_thr && fd <= stable_thr;
      newbg = bgq;
      if (learn) begin
         newbg = bgq + (cur * (1 << FRACTION_BITS) - bgq) / UPDATE_DIVISOR;
         newbg = clamp_int(newbg, 0, int'(BGQ_MAX));
      end

      frame_tally[CNT_BG_DIFF_SUM] = sat_add(frame_tally[CNT_BG_DIFF_SUM], bd, SUM_W);
      frame_tally[CNT_FRAME_DIFF_SUM] = sat_add(frame_tally[CNT_FRAME_DIFF_SUM], fd, SUM_W);
      if (bchg) begin
         frame_tally[CNT_GLOBAL_BG] = sat_add(frame_tally[CNT_GLOBAL_BG], 1, CNT_W);
         if (px.in_gully)
            frame_tally[CNT_GULLY_BG] = sat_add(frame_tally[CNT_GULLY_BG], 1, CNT_W);
         if (px.in_static)
            frame_tally[CNT_STATIC_BG] = sat_add(frame_tally[CNT_STATIC_BG], 1, CNT_W);
      end
      if (fchg) begin
         frame_tally[CNT_GLOBAL_FRAME] = sat_add(frame_tally[CNT_GLOBAL_FRAME], 1, CNT_W);
         if (px.in_gully)
            frame_tally[CNT_GULLY_FRAME] = sat_add(frame_tally[CNT_GULLY_FRAME], 1, CNT_W);
         else
            frame_tally[CNT_ZONE0 + px.quadrant] =
               sat_add(frame_tally[CNT_ZONE0 + px.quadrant], 1, CNT_W);
         if (px.in_static)
            frame_tally[CNT_STATIC_FRAME] = sat_add(frame_tally[CNT_STATIC_FRAME], 1, CNT_W);
      end
      if (px.in_gully && bchg && fchg)
         frame_tally[CNT_OVERLAP] = sat_add(frame_tally[CNT_OVERLAP], 1, CNT_W);
      if (learn)
         frame_tally[CNT_LEARNED] = sat_add(frame_tally[CNT_LEARNED], 1, CNT_W);
      frame_tally[CNT_BG_TOTAL] = sat_add(frame_tally[CNT_BG_TOTAL], newbg, TOT_W);

      r = '0;
      r.kind = KIND_PIXEL;
      r.new_bkg_q8 = BGQ_W'(newbg);
      r.background_changed = bchg;
      r.frame_changed = fchg;
      r.foreground_mark = px.in_gully && bchg;
      r.moving_overlap = px.in_gully && bchg && fchg;
      r.learned = learn;
      r.last_result = !px.last_pixel;
      expected_beats.push_back(r);
      if (px.last_pixel) begin
         for (k = 0; k < NUM_COUNTERS; k++) begin
            r = '0;
            r.kind = KIND_COUNTER;
            r.counter_index = CIDX_W'(k);
            r.counter_value = TOT_W'(frame_tally[k]);
            r.last_result = (k == NUM_COUNTERS - 1);
            expected_beats.push_back(r);
         end
         clear_tally();
      end
   endfunction

   task automatic check_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   task automatic compare_beat(rsp_type e, rsp_type a);
      check_field("kind", longint'(e.kind), longint'(a.kind));
      check_field("new_bkg_q8", longint'(e.new_bkg_q8), longint'(a.new_bkg_q8));
      check_field("background_changed", longint'(e.background_changed),
                  longint'(a.background_changed));
      check_field("frame_changed", longint'(e.frame_changed), longint'(a.frame_changed));
      check_field("foreground_mark", longint'(e.foreground_mark),
                  longint'(a.foreground_mark));
      check_field("moving_overlap", longint'(e.moving_overlap), longint'(a.moving_overlap));
      check_field("learned", longint'(e.learned), longint'(a.learned));
      check_field("counter_index", longint'(e.counter_index), longint'(a.counter_index));
      check_field("counter_value", longint'(e.counter_value), longint'(a.counter_value));
      check_field("last_result", longint'(e.last_result), longint'(a.last_result));
   endtask

   always @(posedge clock) begin
      req_accepted = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("Result beat arrived with no expectation pending.");
               error_count++;
            end else begin
               compare_beat(expected_beats.pop_front(), rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            req_accepted = 1'b1;
            predict_pixel(req_data);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (!req_valid || req_accepted) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pixel_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_BACKGROUND_SHIFT: bkg_offset = int'($signed(data));
         REG_FRAME_SHIFT: fr_shift = int'($signed(data));
         REG_ALLOW_LEARNING: learn_en = data[0];
         REG_BACKGROUND_THRESHOLD: bg_thr = int'(data[7:0]);
         REG_FRAME_THRESHOLD: fr_thr = int'(data[7:0]);
         REG_LEARN_THRESHOLD: learn_thr = int'(data[7:0]);
         REG_STABLE_THRESHOLD: stable_thr = int'(data[7:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(int bs, int fs, int al, int bt, int ft, int lt, int st);
      write_reg(REG_BACKGROUND_SHIFT, bs);
      write_reg(REG_FRAME_SHIFT, fs);
      write_reg(REG_ALLOW_LEARNING, al);
      write_reg(REG_BACKGROUND_THRESHOLD, bt);
      write_reg(REG_FRAME_THRESHOLD, ft);
      write_reg(REG_LEARN_THRESHOLD, lt);
      write_reg(REG_STABLE_THRESHOLD, st);
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pixel_queue.size() != 0 || expected_beats.size() != 0 ||
                 (req_valid && !req_accepted));
      repeat (2) @(negedge clock);
   endtask

   function automatic req_type make_pixel(logic [7:0] cur, logic [7:0] prev,
                                          logic [15:0] bgq, logic gully, logic stat,
                                          logic [1:0] quad, logic last);
      req_type px;
      px.current_pixel = cur;
      px.previous_pixel = prev;
      px.bkg_q8 = bgq;
      px.in_gully = gully;
      px.in_static = stat;
      px.quadrant = quad;
      px.last_pixel = last;
      return px;
   endfunction

   function automatic req_type random_pixel(logic last);
      req_type px;
      int cur, noise;
      cur = $urandom_range(255);
      px.current_pixel = PIX_W'(cur);
      px.in_gully = 1'($urandom_range(1));
      px.in_static = 1'($urandom_range(1));
      px.quadrant = 2'($urandom_range(3));
      px.last_pixel = last;
      if ($urandom_range(9) < 7) begin
         px.previous_pixel = PIX_W'(clamp_int(cur + int'($urandom_range(16)) - 8, 0, 255));
         noise = int'($urandom_range(6000)) - 3000;
         px.bkg_q8 = BGQ_W'(clamp_int(cur * 256 + noise, 0, int'(BGQ_MAX)));
      end else begin
         px.previous_pixel = PIX_W'($urandom_range(255));
         if ($urandom_range(7) == 0)
            px.bkg_q8 = BGQ_W'(int'(BGQ_MAX) + 1 + int'($urandom_range(254)));
         else
            px.bkg_q8 = BGQ_W'($urandom_range(65535));
      end
      return px;
   endfunction

   initial begin
      int p, i, flen, count;
      clear_tally();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      pixel_queue.push_back(make_pixel(0, 0, 0, 0, 0, 0, 0));
      pixel_queue.push_back(make_pixel(255, 255, 65280, 1, 1, 3, 0));
      pixel_queue.push_back(make_pixel(255, 0, 0, 1, 0, 1, 0));
      pixel_queue.push_back(make_pixel(0, 255, 65535, 0, 1, 2, 0));
      pixel_queue.push_back(make_pixel(128, 128, 16'h7F80, 1, 1, 0, 0));
      pixel_queue.push_back(make_pixel(100, 90, 16'h647F, 0, 0, 3, 0));
      pixel_queue.push_back(make_pixel(30, 20, 0, 0, 1, 0, 1));
      wait_idle();

      set_config(-256, 255, 1, 255, 255, 255, 255);
      @(posedge clock);
      pixel_queue.push_back(make_pixel(0, 0, 65535, 1, 0, 2, 0));
      pixel_queue.push_back(make_pixel(255, 255, 0, 0, 1, 1, 0));
      pixel_queue.push_back(make_pixel(200, 3, 65535, 1, 1, 3, 0));
      pixel_queue.push_back(make_pixel(17, 0, 16'h110F, 0, 0, 0, 0));
      pixel_queue.push_back(make_pixel(17, 0, 16'h10F1, 1, 0, 1, 0));
      pixel_queue.push_back(make_pixel(255, 128, 65280, 0, 1, 2, 1));
      wait_idle();

      for (p = 0; p < 6; p++) begin
         case (p)
            0: set_config(0, 0, 1, 25, 15, 10, 5);
            1: set_config(-255, 255, 1, 0, 0, 255, 255);
            3: set_config(0, 0, 1, 255, 255, 0, 0);
            5: set_config(-20, 20, 1, 40, 30, 12, 8);
            default: set_config(int'($urandom_range(511)) - 256, int'($urandom_range(511)) - 256,
                                $urandom_range(1), $urandom_range(255), $urandom_range(255),
                                $urandom_range(255), $urandom_range(255));
         endcase
         if (p < 2) begin
            send_idle_pct = 11;
            recv_stall_pct = 49;
         end else if (p < 4) begin
            send_idle_pct = 49;
            recv_stall_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         @(posedge clock);
         count = 0;
         while (count < 38) begin
            flen = ($urandom_range(4) == 0) ? 1 : int'($urandom_range(12, 2));
            for (i = 0; i < flen; i++)
               pixel_queue.push_back(random_pixel(i == flen - 1));
            count += flen;
         end
         wait_idle();
      end

      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
